/* design/trd_pkg.sv */
package trd_pkg;

    typedef struct packed {
        logic [7:0] report_byte;
        logic       start_of_report;
    } trd_in_t;

    typedef struct packed {
        logic        report_status;
        logic [1:0]  point_count;
        logic [3:0]  first_track;
        logic [11:0] first_x;
        logic [11:0] first_y;
        logic [3:0]  second_track;
        logic [11:0] second_x;
        logic [11:0] second_y;
    } trd_out_t;

    typedef struct packed {
        logic [3:0]  track;
        logic [11:0] x;
        logic [11:0] y;
    } trd_point_t;

    localparam int          COORD_W     = 12;
    localparam int          SLOT_LEN    = 6;
    localparam logic [2:0]  SLOT_LAST_K = 3'(SLOT_LEN - 1);

    localparam logic [2:0]  BYTE_EV_XH  = 3'd0;
    localparam logic [2:0]  BYTE_XL     = 3'd1;
    localparam logic [2:0]  BYTE_ID_YH  = 3'd2;
    localparam logic [2:0]  BYTE_YL     = 3'd3;

    localparam logic [3:0]  NO_TRACK    = 4'hf;
    localparam logic [1:0]  EV_DOWN     = 2'd0;
    localparam logic [1:0]  EV_CONTACT  = 2'd2;

    localparam logic        CFG_X_LIMIT = 1'b0;
    localparam logic        CFG_Y_LIMIT = 1'b1;

    localparam logic        STATUS_OK   = 1'b0;
    localparam logic        STATUS_BAD  = 1'b1;

endpackage

/* design/touch_report_decoder_top.sv */
// Byte-serial decoder for a capacitive touch controller report: one status
// byte (start_of_report set, low nibble = contact count) followed by
// SLOT_COUNT six-byte slots. Each accepted byte is registered, then decoded
// by a single pass of field logic into the state and the result register,
// so one byte is taken every cycle, stalling only while a result waits on
// m_ready; a report's last byte passes the input and result registers to m_data.
// Exactly one result is produced per complete report; a new start flag
// drops an open report, and bytes outside a report are ignored. Invalid
// reports return status 1 with the previously held points. The user must
// write x_limit and y_limit through the cfg port (index 0 and 1) only while
// no item is in flight; the block does not enforce this.
module touch_report_decoder_top #(
    parameter int SLOT_COUNT = 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [11:0]             cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  trd_pkg::trd_in_t        s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output trd_pkg::trd_out_t       m_data
);

    localparam int LAST_INDEX = SLOT_COUNT * trd_pkg::SLOT_LEN;
    localparam int POS_W      = $clog2(LAST_INDEX + 1);

    logic                     in_valid_reg, in_valid_next;
    trd_pkg::trd_in_t         in_data_reg, in_data_next;
    logic                     m_valid_reg, m_valid_next;
    trd_pkg::trd_out_t        out_reg, out_next;

    logic [11:0]              x_limit_reg, x_limit_next;
    logic [11:0]              y_limit_reg, y_limit_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [2:0]               k_reg, k_next;
    logic [3:0]               count_reg, count_next;
    logic [7:0]               slot0_reg, slot0_next;
    logic [7:0]               slot1_reg, slot1_next;
    logic [7:0]               slot2_reg, slot2_next;
    logic [1:0]               found_count_reg, found_count_next;
    trd_pkg::trd_point_t      found0_reg, found0_next;
    trd_pkg::trd_point_t      found1_reg, found1_next;
    logic                     bad_reg, bad_next;
    logic [1:0]               held_count_reg, held_count_next;
    trd_pkg::trd_point_t      held0_reg, held0_next;
    trd_pkg::trd_point_t      held1_reg, held1_next;

    logic                     process;
    logic [1:0]               ev;
    trd_pkg::trd_point_t      cand;

    assign process = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || process;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign ev         = slot0_reg[7:6];
    assign cand.track = slot2_reg[7:4];
    assign cand.x     = {slot0_reg[3:0], slot1_reg};
    assign cand.y     = {slot2_reg[3:0], in_data_reg.report_byte};

    always_comb begin
        in_valid_next    = in_valid_reg && !process;
        in_data_next     = in_data_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        out_next         = out_reg;
        x_limit_next     = x_limit_reg;
        y_limit_next     = y_limit_reg;
        pos_next         = pos_reg;
        k_next           = k_reg;
        count_next       = count_reg;
        slot0_next       = slot0_reg;
        slot1_next       = slot1_reg;
        slot2_next       = slot2_reg;
        found_count_next = found_count_reg;
        found0_next      = found0_reg;
        found1_next      = found1_reg;
        bad_next         = bad_reg;
        held_count_next  = held_count_reg;
        held0_next       = held0_reg;
        held1_next       = held1_reg;

        if (cfg_we) begin
            if (cfg_index == trd_pkg::CFG_X_LIMIT) begin
                x_limit_next = cfg_wdata;
            end else begin
                y_limit_next = cfg_wdata;
            end
        end

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_data_next  = s_data;
        end

        if (process) begin
            if (in_data_reg.start_of_report) begin
                count_next       = in_data_reg.report_byte[3:0];
                found_count_next = 2'd0;
                bad_next         = in_data_reg.report_byte[3:0] > 4'(SLOT_COUNT);
                pos_next         = POS_W'(1);
                k_next           = trd_pkg::BYTE_EV_XH;
            end else if (pos_reg != '0) begin
                case (k_reg)
                    trd_pkg::BYTE_EV_XH: slot0_next = in_data_reg.report_byte;
                    trd_pkg::BYTE_XL:    slot1_next = in_data_reg.report_byte;
                    trd_pkg::BYTE_ID_YH: slot2_next = in_data_reg.report_byte;
                    trd_pkg::BYTE_YL: begin
                        if (!bad_reg && count_reg != 4'd0 &&
                            cand.track != trd_pkg::NO_TRACK &&
                            (ev == trd_pkg::EV_DOWN || ev == trd_pkg::EV_CONTACT)) begin
                            if (cand.x > x_limit_reg || cand.y > y_limit_reg ||
                                (found_count_reg != 2'd0 &&
                                 found0_reg.track == cand.track)) begin
                                bad_next = 1'b1;
                            end else if (found_count_reg == 2'd0) begin
                                found0_next      = cand;
                                found_count_next = 2'd1;
                            end else if (found_count_reg == 2'd1) begin
                                found1_next      = cand;
                                found_count_next = 2'd2;
                            end
                        end
                    end
                    default: ;
                endcase

                if (pos_reg < POS_W'(LAST_INDEX)) begin
                    pos_next = pos_reg + POS_W'(1);
                    k_next   = (k_reg == trd_pkg::SLOT_LAST_K) ? trd_pkg::BYTE_EV_XH
                                                             : k_reg + 3'd1;
                end else begin
                    pos_next = '0;
                    if (!bad_next && {2'b00, found_count_next} == count_reg) begin
                        held_count_next = found_count_next;
                        if (found_count_next != 2'd0) begin
                            held0_next = found0_next;
                        end
                        if (found_count_next == 2'd2) begin
                            held1_next = found1_next;
                        end
                    end else begin
                        bad_next = 1'b1;
                    end

                    m_valid_next           = 1'b1;
                    out_next.report_status = bad_next ? trd_pkg::STATUS_BAD
                                                      : trd_pkg::STATUS_OK;
                    out_next.point_count   = held_count_next;
                    out_next.first_track   = '0;
                    out_next.first_x       = '0;
                    out_next.first_y       = '0;
                    out_next.second_track  = '0;
                    out_next.second_x      = '0;
                    out_next.second_y      = '0;
                    if (held_count_next != 2'd0) begin
                        out_next.first_track = held0_next.track;
                        out_next.first_x     = held0_next.x;
                        out_next.first_y     = held0_next.y;
                    end
                    if (held_count_next == 2'd2) begin
                        out_next.second_track = held1_next.track;
                        out_next.second_x     = held1_next.x;
                        out_next.second_y     = held1_next.y;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            x_limit_reg     <= '1;
            y_limit_reg     <= '1;
            pos_reg         <= '0;
            k_reg           <= trd_pkg::BYTE_EV_XH;
            count_reg       <= 4'd0;
            found_count_reg <= 2'd0;
            bad_reg         <= 1'b0;
            held_count_reg  <= 2'd0;
            held0_reg       <= '0;
            held1_reg       <= '0;
        end else begin
            in_valid_reg    <= in_valid_next;
            m_valid_reg     <= m_valid_next;
            x_limit_reg     <= x_limit_next;
            y_limit_reg     <= y_limit_next;
            pos_reg         <= pos_next;
            k_reg           <= k_next;
            count_reg       <= count_next;
            found_count_reg <= found_count_next;
            bad_reg         <= bad_next;
            held_count_reg  <= held_count_next;
            held0_reg       <= held0_next;
            held1_reg       <= held1_next;
        end
        in_data_reg <= in_data_next;
        out_reg     <= out_next;
        slot0_reg   <= slot0_next;
        slot1_reg   <= slot1_next;
        slot2_reg   <= slot2_next;
        found0_reg  <= found0_next;
        found1_reg  <= found1_next;
    end

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(LAST_INDEX))
        else $error("byte position past end of report");

    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg <= 2'(SLOT_COUNT))
        else $error("held point count exceeds slot count");

    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data.point_count != 2'd2 |->
            m_data.second_track == 4'd0 && m_data.second_x == 12'd0 &&
            m_data.second_y == 12'd0)
        else $error("unused point fields not zero");

    a_last_byte_result: assert property (@(posedge aclk) disable iff (!aresetn)
        process && !in_data_reg.start_of_report && pos_reg == POS_W'(LAST_INDEX)
            |=> m_valid_reg && pos_reg == '0)
        else $error("last byte gave no result");
`endif

endmodule

/* bench/trd_check_pkg.sv */
package trd_check_pkg;
    import trd_pkg::*;

    localparam int SLOTS    = 2;
    localparam int LAST_POS = SLOTS * SLOT_LEN;

    class touch_decode_checker;
        trd_out_t    pending_reports[$];
        int unsigned errors;
        logic [11:0] x_limit;
        logic [11:0] y_limit;
        logic [3:0]  byte_pos;
        logic [3:0]  contact_count;
        logic [7:0]  slot_byte[3];
        logic [1:0]  found_count;
        trd_point_t  found_pt[2];
        logic        report_bad;
        logic [1:0]  held_count;
        trd_point_t  held_pt[2];

        function new();
            errors        = 0;
            x_limit       = '1;
            y_limit       = '1;
            byte_pos      = '0;
            contact_count = '0;
            found_count   = '0;
            report_bad    = 1'b0;
            held_count    = '0;
            for (int i = 0; i < 3; i++) slot_byte[i] = '0;
            for (int i = 0; i < 2; i++) begin
                found_pt[i] = '0;
                held_pt[i]  = '0;
            end
        endfunction

        function void set_limit(logic idx, logic [11:0] val);
            if (idx == CFG_X_LIMIT) begin
                x_limit = val;
            end else begin
                y_limit = val;
            end
        endfunction

        function void take_byte(trd_in_t item);
            int unsigned k;
            logic [1:0]  ev;
            logic [3:0]  id;
            trd_point_t  pt;
            trd_out_t    res;
            if (item.start_of_report) begin
                contact_count = item.report_byte[3:0];
                found_count   = '0;
                report_bad    = (contact_count > SLOTS);
                byte_pos      = 4'd1;
                return;
            end
            if (byte_pos == 0) return;

            k = (byte_pos - 1) % SLOT_LEN;
            if (k < BYTE_YL) begin
                slot_byte[k] = item.report_byte;
            end else if (k == BYTE_YL && !report_bad && contact_count != 0) begin
                ev = slot_byte[BYTE_EV_XH][7:6];
                id = slot_byte[BYTE_ID_YH][7:4];
                if (id != NO_TRACK && (ev == EV_DOWN || ev == EV_CONTACT)) begin
                    pt.track = id;
                    pt.x     = {slot_byte[BYTE_EV_XH][3:0], slot_byte[BYTE_XL]};
                    pt.y     = {slot_byte[BYTE_ID_YH][3:0], item.report_byte};
                    if (pt.x > x_limit || pt.y > y_limit ||
                        (found_count != 0 && found_pt[0].track == id)) begin
                        report_bad = 1'b1;
                    end else if (found_count < 2) begin
                        found_pt[found_count] = pt;
                        found_count++;
                    end
                end
            end

            if (byte_pos < LAST_POS) begin
                byte_pos++;
                return;
            end

            byte_pos = '0;
            if (!report_bad && found_count == contact_count) begin
                held_count = found_count;
                for (int i = 0; i < found_count; i++) held_pt[i] = found_pt[i];
            end else begin
                report_bad = 1'b1;
            end

            res               = '0;
            res.report_status = report_bad ? STATUS_BAD : STATUS_OK;
            res.point_count   = held_count;
            if (held_count > 0) begin
                res.first_track = held_pt[0].track;
                res.first_x     = held_pt[0].x;
                res.first_y     = held_pt[0].y;
            end
            if (held_count > 1) begin
                res.second_track = held_pt[1].track;
                res.second_x     = held_pt[1].x;
                res.second_y     = held_pt[1].y;
            end
            pending_reports.push_back(res);
        endfunction

        function void compare_field(string name, logic [11:0] want, logic [11:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(trd_out_t got);
            trd_out_t want;
            if (pending_reports.size() == 0) begin
                $error("unexpected result: status %0d, point_count %0d",
                       got.report_status, got.point_count);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            compare_field("report_status", want.report_status, got.report_status);
            compare_field("point_count", want.point_count, got.point_count);
            compare_field("first_track", want.first_track, got.first_track);
            compare_field("first_x", want.first_x, got.first_x);
            compare_field("first_y", want.first_y, got.first_y);
            compare_field("second_track", want.second_track, got.second_track);
            compare_field("second_x", want.second_x, got.second_x);
            compare_field("second_y", want.second_y, got.second_y);
        endfunction
    endclass

endpackage

/* bench/touch_report_decoder_top_test.sv */
module touch_report_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import trd_pkg::*;
    import trd_check_pkg::*;

    localparam int         CLK_PERIOD        = 10;
    localparam int         CYCLE_LIMIT       = 200000;
    localparam int         SETTLE_CYCLES     = 6;
    localparam int         REPORTS_PER_PHASE = 5;
    localparam int         PHASES            = 6;
    localparam logic [1:0] EV_LIFT           = 2'd1;
    localparam logic [1:0] EV_NONE           = 2'd3;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_X_LIMIT;
    logic [11:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    trd_in_t     s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    trd_out_t    m_data;

    touch_decode_checker sb;
    bit          idle_on     = 1'b1;
    int          cycle_count = 0;
    logic [11:0] cur_x_limit = 12'hfff;
    logic [11:0] cur_y_limit = 12'hfff;

    touch_report_decoder_top #(.SLOT_COUNT(2)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_report(m_data);
            if (s_valid && s_ready) sb.take_byte(s_data);
        end
    end

    always @(negedge aclk) begin
        m_ready <= !(idle_on && $urandom_range(99) < 29);
    end

    task automatic send_byte(input logic [7:0] value, input logic start);
        while (idle_on && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{report_byte: value, start_of_report: start};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending_reports.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input logic idx, input logic [11:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.set_limit(idx, val);
        if (idx == CFG_X_LIMIT) begin
            cur_x_limit = val;
        end else begin
            cur_y_limit = val;
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [11:0] pick_coord(input logic [11:0] lim);
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return lim;
        if (r == 2 && lim != 12'hfff) return 12'($urandom_range(4095, int'(lim) + 1));
        return 12'($urandom_range(int'(lim)));
    endfunction

    task automatic random_report(input bit may_cut);
        logic [7:0]  body [12];
        logic [3:0]  first_id;
        logic [3:0]  id;
        logic [1:0]  ev;
        logic [11:0] x;
        logic [11:0] y;
        int          accepted;
        int          count;
        int          len;
        int unsigned mode;
        int unsigned r;
        accepted = 0;
        first_id = '0;
        for (int s = 0; s < SLOTS; s++) begin
            mode = $urandom_range(9);
            ev   = $urandom_range(1) ? EV_CONTACT : EV_DOWN;
            id   = 4'($urandom_range(14));
            if (s == 1 && $urandom_range(5) == 0) id = first_id;
            if (mode < 2) begin
                id = NO_TRACK;
            end else if (mode < 3) begin
                ev = $urandom_range(1) ? EV_LIFT : EV_NONE;
            end else begin
                accepted++;
            end
            x = pick_coord(cur_x_limit);
            y = pick_coord(cur_y_limit);
            body[6 * s + 0] = {ev, 2'($urandom_range(3)), x[11:8]};
            body[6 * s + 1] = x[7:0];
            body[6 * s + 2] = {id, y[11:8]};
            body[6 * s + 3] = y[7:0];
            body[6 * s + 4] = 8'($urandom);
            body[6 * s + 5] = 8'($urandom);
            if (mode == 9) begin
                for (int i = 0; i < SLOT_LEN; i++) body[6 * s + i] = 8'($urandom);
            end
            first_id = id;
        end

        r = $urandom_range(9);
        if (r < 7) begin
            count = accepted;
        end else if (r < 9) begin
            count = $urandom_range(2);
        end else begin
            count = $urandom_range(15, 3);
        end
        len = (may_cut && $urandom_range(9) == 0) ? $urandom_range(11) : LAST_POS;

        send_byte({4'($urandom), 4'(count)}, 1'b1);
        for (int i = 0; i < len; i++) send_byte(body[i], 1'b0);
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
        end
    endtask

    initial begin
        logic [7:0]  demo_report [13] = '{
            8'hf2,
            8'h3f, 8'hff, 8'h00, 8'h00, 8'hff, 8'hff,
            8'h80, 8'h00, 8'hef, 8'hff, 8'h00, 8'h00
        };
        logic [11:0] xl;
        logic [11:0] yl;

        sb = new();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ignored before the first start, then a report dropped by a new start
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h3f, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hef, 1'b0);
        for (int i = 0; i < 13; i++) send_byte(demo_report[i], i == 0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h55, 1'b0);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: begin xl = 12'h000; yl = 12'h000; end
                2: begin xl = 12'hfff; yl = 12'hfff; end
                3: begin xl = 12'h000; yl = 12'hfff; end
                4: begin xl = 12'hfff; yl = 12'h000; end
                default: begin
                    xl = 12'($urandom_range(4095));
                    yl = 12'($urandom_range(4095));
                end
            endcase
            write_limit(CFG_X_LIMIT, xl);
            write_limit(CFG_Y_LIMIT, yl);
            idle_on = (phase != 2);
            for (int n = 0; n < REPORTS_PER_PHASE; n++) begin
                random_report(n != REPORTS_PER_PHASE - 1);
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
